// ===== sv/per_flow_token_bucket_macros.svh =====
// ----------------------------------------------------------------------------
// per_flow_token_bucket_macros
// assertion macros used by the checker file of the rate limiter
// ----------------------------------------------------------------------------
`ifndef PER_FLOW_TOKEN_BUCKET_MACROS_SVH
`define PER_FLOW_TOKEN_BUCKET_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define PFTB_CHECK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("per_flow_token_bucket check failed");

// next-cycle implication, sampled on clk, off during rst
`define PFTB_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> (cons)) \
    else $error("per_flow_token_bucket check failed");

`endif

// ===== sv/pftb_pkg.sv =====
// ----------------------------------------------------------------------------
// pftb_pkg
// types and constants of the per-flow token bucket rate limiter
// ----------------------------------------------------------------------------
package pftb_pkg;

  localparam int FLOW_COUNT_DEFAULT = 256;
  localparam int FLOW_ID_W          = 8;
  localparam int FLOW_ID_SPAN       = 2 ** FLOW_ID_W;
  localparam int TOKEN_W            = 32;

  localparam logic [TOKEN_W-1:0] DEFAULT_MAX_RESET  = 32'd6553600;
  localparam logic [TOKEN_W-1:0] DEFAULT_RATE_RESET = 32'd65536;

  // configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEFAULT_MAX  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEFAULT_RATE = 1'd1;

  typedef enum logic [1:0] {
    MODE_REQUEST  = 2'd0,
    MODE_SET      = 2'd1,
    MODE_QUERY    = 2'd2,
    MODE_RESERVED = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                mode;
    logic [FLOW_ID_W-1:0] flow_id;
    logic [TOKEN_W-1:0]   cost;
    logic [31:0]          timestamp;
    logic [TOKEN_W-1:0]   new_max_tokens;
    logic [TOKEN_W-1:0]   new_refill_rate;
  } req_t;

  typedef struct packed {
    logic               allowed;
    logic [TOKEN_W-1:0] tokens_level;
  } res_t;

  // one flow entry as stored in the bucket memory
  typedef struct packed {
    logic [TOKEN_W-1:0] level;
    logic [TOKEN_W-1:0] capacity;
    logic [TOKEN_W-1:0] rate;
    logic [31:0]        last_tick;
  } entry_t;

  // write-back request from the update logic
  typedef struct packed {
    logic   en;
    entry_t data;
  } wr_t;

endpackage

// ===== sv/pftb_ram.sv =====
// ----------------------------------------------------------------------------
// pftb_ram
// flow entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module pftb_ram #(
  parameter int DEPTH = pftb_pkg::FLOW_COUNT_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output pftb_pkg::entry_t             rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  pftb_pkg::entry_t             wr_data
);

  pftb_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-before-write on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/pftb_calc.sv =====
// ----------------------------------------------------------------------------
// pftb_calc
// refill, cost check and result for one beat against one flow entry
// ----------------------------------------------------------------------------
module pftb_calc (
  input  pftb_pkg::req_t                      item,
  input  logic                                hit,
  input  pftb_pkg::entry_t                    entry,
  input  logic [pftb_pkg::TOKEN_W-1:0]        dflt_max,
  input  logic [pftb_pkg::TOKEN_W-1:0]        dflt_rate,
  output pftb_pkg::res_t                      result,
  output pftb_pkg::wr_t                       wr
);

  localparam int TW = pftb_pkg::TOKEN_W;

  pftb_pkg::entry_t base;
  logic [31:0]      elapsed;
  logic [2*TW-1:0]  prod;
  logic [TW-1:0]    incr;
  logic [TW:0]      sum;
  logic [TW-1:0]    refilled;
  logic             fits;
  logic [TW-1:0]    stored;

  // unused entry starts full with the default settings
  always_comb begin
    if (hit) begin
      base = entry;
    end else begin
      base.level     = dflt_max;
      base.capacity  = dflt_max;
      base.rate      = dflt_rate;
      base.last_tick = item.timestamp;
    end
  end

  assign elapsed  = item.timestamp - base.last_tick;
  assign prod     = (2*TW)'(elapsed) * (2*TW)'(base.rate);
  assign incr     = (|prod[2*TW-1:TW]) ? {TW{1'b1}} : prod[TW-1:0];
  assign sum      = {1'b0, base.level} + {1'b0, incr};
  assign refilled = (sum > {1'b0, base.capacity}) ? base.capacity : sum[TW-1:0];
  assign fits     = (refilled >= item.cost);
  assign stored   = hit ? entry.level : dflt_max;

  always_comb begin
    result.allowed      = 1'b1;
    result.tokens_level = stored;
    wr.en               = 1'b0;
    wr.data.level       = refilled;
    wr.data.capacity    = base.capacity;
    wr.data.rate        = base.rate;
    wr.data.last_tick   = item.timestamp;
    case (item.mode)
      pftb_pkg::MODE_REQUEST: begin
        // zero cost is a plain look, no entry created
        if (item.cost != '0) begin
          wr.en = 1'b1;
          if (fits) begin
            wr.data.level = refilled - item.cost;
          end else begin
            result.allowed = 1'b0;
          end
          result.tokens_level = wr.data.level;
        end
      end
      pftb_pkg::MODE_SET: begin
        wr.en               = 1'b1;
        wr.data.level       = item.new_max_tokens;
        wr.data.capacity    = item.new_max_tokens;
        wr.data.rate        = item.new_refill_rate;
        result.tokens_level = item.new_max_tokens;
      end
      pftb_pkg::MODE_QUERY: begin
        result.tokens_level = stored;
      end
      default: begin
        result.allowed      = 1'b0;
        result.tokens_level = '0;
      end
    endcase
  end

endmodule

// ===== sv/per_flow_token_bucket.sv =====
// path: a beat accepted passes the stage 1 register, then the result register (res_valid high)
// throughput: one beat per cycle while res is not stalled; each beat reads its flow
//   entry, and request beats of nonzero cost and set beats write it back, with the last write forwarded to the next
// reset: valid marks of all flows clear together, defaults return to their
//   reset values, pipeline and output empty; entry memory itself is not cleared
// ----------------------------------------------------------------------------
// per_flow_token_bucket
// table of token buckets indexed by flow, with request, set and query beats
// ----------------------------------------------------------------------------
module per_flow_token_bucket #(
  parameter int FLOW_COUNT = pftb_pkg::FLOW_COUNT_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                req_valid,
  output logic                                req_stall,
  input  pftb_pkg::req_t                      req,
  // result channel
  output logic                                res_valid,
  input  logic                                res_stall,
  output pftb_pkg::res_t                      res,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [pftb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pftb_pkg::TOKEN_W-1:0]        cfg_data
);

  // only 256 flow ids exist, so the table never needs more rows than that
  localparam int DEPTH = (FLOW_COUNT < pftb_pkg::FLOW_ID_SPAN) ?
                         FLOW_COUNT : pftb_pkg::FLOW_ID_SPAN;
  localparam int IDX_W = $clog2(DEPTH);

  // flow id to row, i.e. flow_id modulo FLOW_COUNT, as a constant lookup
  function automatic logic [IDX_W-1:0] flow_row(input logic [pftb_pkg::FLOW_ID_W-1:0] id);
    logic [IDX_W-1:0] row;
    int               k;
    row = '0;
    k   = 0;
    for (int i = 0; i < pftb_pkg::FLOW_ID_SPAN; i++) begin
      if (int'(id) == i) begin
        row = IDX_W'(k);
      end
      k = (k + 1 == DEPTH) ? 0 : k + 1;
    end
    return row;
  endfunction

  // default settings for flows without their own
  logic [pftb_pkg::TOKEN_W-1:0] dflt_max;
  logic [pftb_pkg::TOKEN_W-1:0] dflt_rate;

  // stage 1: item waiting on its entry read
  logic                 s1_valid;
  pftb_pkg::req_t       s1_item;
  logic [IDX_W-1:0]     s1_idx;

  // one valid mark per row, cleared by reset
  logic [DEPTH-1:0]     entry_valid;

  // last write, forwarded to a read that raced it
  logic                 byp_valid;
  logic [IDX_W-1:0]     byp_idx;
  pftb_pkg::entry_t     byp_data;

  logic                 advance;
  logic                 accept;
  logic                 wr_fire;
  logic [IDX_W-1:0]     req_idx;
  pftb_pkg::entry_t     rd_data;
  pftb_pkg::entry_t     entry;
  pftb_pkg::res_t       result;
  pftb_pkg::wr_t        wr;

  assign advance   = !res_valid || !res_stall;
  assign req_stall = s1_valid && !advance;
  assign accept    = req_valid && !req_stall;
  assign req_idx   = flow_row(req.flow_id);
  assign wr_fire   = s1_valid && advance && wr.en;

  // prefer the forwarded write: it is the newest value for its row
  assign entry = (byp_valid && byp_idx == s1_idx) ? byp_data : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      dflt_max  <= pftb_pkg::DEFAULT_MAX_RESET;
      dflt_rate <= pftb_pkg::DEFAULT_RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        pftb_pkg::CFG_DEFAULT_MAX:  dflt_max  <= cfg_data;
        pftb_pkg::CFG_DEFAULT_RATE: dflt_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  pftb_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (req_idx),
    .rd_data (rd_data),
    .wr_en   (wr_fire),
    .wr_addr (s1_idx),
    .wr_data (wr.data)
  );

  pftb_calc u_calc (
    .item      (s1_item),
    .hit       (entry_valid[s1_idx]),
    .entry     (entry),
    .dflt_max  (dflt_max),
    .dflt_rate (dflt_rate),
    .result    (result),
    .wr        (wr)
  );

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance || !s1_valid) begin
      s1_valid <= accept;
    end
  end

  // stage 1 payload, held while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= req;
      s1_idx  <= req_idx;
    end
  end

  // entry valid marks and forwarding register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      byp_valid   <= 1'b0;
    end else if (wr_fire) begin
      entry_valid[s1_idx] <= 1'b1;
      byp_valid           <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      byp_idx  <= s1_idx;
      byp_data <= wr.data;
    end
  end

  // result register, parts the result side from the request side
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res <= result;
    end
  end

endmodule

// ===== sv/pftb_checker.sv =====
// ----------------------------------------------------------------------------
// pftb_checker
// port-level checks of the rate limiter, bound to the top level
// ----------------------------------------------------------------------------
`include "per_flow_token_bucket_macros.svh"

module pftb_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           res_valid,
  input logic           res_stall,
  input pftb_pkg::res_t res
);

  // a stalled result beat stays and holds its payload
  `PFTB_CHECK_NEXT(res_hold_valid, (res_valid && res_stall), res_valid)
  `PFTB_CHECK_NEXT(res_hold_data, (res_valid && res_stall), $stable(res))

  // an empty result register never pushes back on requests
  `PFTB_CHECK_NOW(req_free_when_empty, !res_valid, !req_stall)

  // an accepted beat reaches the result register when the result side keeps taking beats
  `PFTB_CHECK_NEXT(two_cycle_latency, (req_valid && !req_stall ##1 !res_stall), res_valid)

endmodule

bind per_flow_token_bucket pftb_checker u_pftb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
